// File: design/ptrs_pkg.sv
package ptrs_pkg;

    localparam int TASK_SLOTS  = 16;
    localparam int COUNT_WIDTH = 16;

    localparam int CNT_W = $clog2(TASK_SLOTS + 1);

    localparam logic [7:0] TICK_DIVIDE_RESET = 8'd4;

    localparam logic [2:0] FUNC_TICK    = 3'd0;
    localparam logic [2:0] FUNC_CREATE  = 3'd1;
    localparam logic [2:0] FUNC_SUSPEND = 3'd2;
    localparam logic [2:0] FUNC_RESUME  = 3'd3;
    localparam logic [2:0] FUNC_DELETE  = 3'd4;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PASS,
        OP_CREATE,
        OP_SUSPEND,
        OP_RESUME,
        OP_DELETE
    } slot_op_t;

    typedef struct packed {
        logic     exec;
        slot_op_t op;
    } slot_cmd_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] period;
        logic [15:0] first_delay;
        logic [3:0]  task_index;
    } cmd_item_t;

    typedef struct packed {
        logic [15:0] fire_mask;
        logic [4:0]  task_count;
        logic [1:0]  status;
    } rsp_item_t;

endpackage

// File: design/ptrs_slot_table.sv
module ptrs_slot_table
    import ptrs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  slot_cmd_t              cmd,
    input  logic [COUNT_WIDTH-1:0] period,
    input  logic [COUNT_WIDTH-1:0] first_delay,
    input  logic [3:0]             task_index,
    output logic [TASK_SLOTS-1:0]  fired,
    output logic [CNT_W-1:0]       count,
    output logic [CNT_W-1:0]       count_next,
    output logic [1:0]             status
);

    logic [COUNT_WIDTH-1:0] period_reg    [TASK_SLOTS];
    logic [COUNT_WIDTH-1:0] countdown_reg [TASK_SLOTS];
    logic                   suspended_reg [TASK_SLOTS];
    logic [CNT_W-1:0]       count_reg;

    logic [COUNT_WIDTH-1:0] period_next    [TASK_SLOTS];
    logic [COUNT_WIDTH-1:0] countdown_next [TASK_SLOTS];
    logic                   suspended_next [TASK_SLOTS];

    logic [COUNT_WIDTH-1:0] period_up    [TASK_SLOTS];
    logic [COUNT_WIDTH-1:0] countdown_up [TASK_SLOTS];
    logic                   suspended_up [TASK_SLOTS];

    logic index_valid;
    logic table_full;

    // Each slot sees its upper neighbor for the shift on delete.
    for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_up
        if (g + 1 < TASK_SLOTS) begin : g_mid
            assign period_up[g]    = period_reg[g + 1];
            assign countdown_up[g] = countdown_reg[g + 1];
            assign suspended_up[g] = suspended_reg[g + 1];
        end
        else begin : g_top
            assign period_up[g]    = period_reg[g];
            assign countdown_up[g] = countdown_reg[g];
            assign suspended_up[g] = suspended_reg[g];
        end
    end

    assign index_valid = (int'(task_index) < int'(count_reg));
    assign table_full  = (count_reg == CNT_W'(TASK_SLOTS));
    assign count       = count_reg;

    always_comb
    begin
        fired      = '0;
        count_next = count_reg;
        status     = STATUS_OK;
        for (int i = 0; i < TASK_SLOTS; i++)
        begin
            period_next[i]    = period_reg[i];
            countdown_next[i] = countdown_reg[i];
            suspended_next[i] = suspended_reg[i];
        end
        if (cmd.exec)
        begin
            unique case (cmd.op)
                OP_PASS:
                begin
                    for (int i = 0; i < TASK_SLOTS; i++)
                    begin
                        if (CNT_W'(i) < count_reg)
                        begin
                            if (countdown_reg[i] == '0)
                            begin
                                countdown_next[i] = period_reg[i];
                                fired[i]          = !suspended_reg[i];
                            end
                            else
                            begin
                                countdown_next[i] = countdown_reg[i] - 1'b1;
                            end
                        end
                    end
                end
                OP_CREATE:
                begin
                    if (table_full)
                    begin
                        status = STATUS_FULL;
                    end
                    else
                    begin
                        for (int i = 0; i < TASK_SLOTS; i++)
                        begin
                            if (CNT_W'(i) == count_reg)
                            begin
                                period_next[i]    = period;
                                countdown_next[i] = first_delay;
                                suspended_next[i] = 1'b0;
                            end
                        end
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_SUSPEND, OP_RESUME:
                begin
                    if (index_valid)
                    begin
                        for (int i = 0; i < TASK_SLOTS; i++)
                        begin
                            if (int'(task_index) == i)
                            begin
                                suspended_next[i] = (cmd.op == OP_SUSPEND);
                            end
                        end
                    end
                    else
                    begin
                        status = STATUS_BAD_INDEX;
                    end
                end
                OP_DELETE:
                begin
                    if (index_valid)
                    begin
                        for (int i = 0; i < TASK_SLOTS; i++)
                        begin
                            if (i >= int'(task_index) && CNT_W'(i + 1) < count_reg)
                            begin
                                period_next[i]    = period_up[i];
                                countdown_next[i] = countdown_up[i];
                                suspended_next[i] = suspended_up[i];
                            end
                        end
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        status = STATUS_BAD_INDEX;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TASK_SLOTS; i++)
        begin
            period_reg[i]    <= period_next[i];
            countdown_reg[i] <= countdown_next[i];
            suspended_reg[i] <= suspended_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// File: design/periodic_task_release_scheduler_unit.sv
// Pipeline: an accepted item is held in cmd_reg, and its result is registered in rsp_reg
// as the item advances, which waits while an untaken response still sits in rsp_reg.
// Throughput: one item per cycle unless the response stalls; slots update in parallel.
// Reset: rst_n clears the task count, the prescaler and both pipeline stages,
// and sets tick_divide to 4. Slot contents are not cleared.
module periodic_task_release_scheduler_unit
    import ptrs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_item_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp,
    input  logic      cfg_we,
    input  logic [7:0] cfg_wdata
);

    cmd_item_t cmd_reg;
    logic      cmd_vld_reg;
    rsp_item_t rsp_reg;
    logic      rsp_vld_reg;
    logic [7:0] tick_divide_reg;
    logic [7:0] prescale_reg;
    logic [7:0] prescale_next;
    logic [7:0] prescale_inc;

    logic      advance;
    slot_cmd_t slot_cmd;
    rsp_item_t rsp_next;

    logic [TASK_SLOTS-1:0]    fired;
    logic [TASK_SLOTS+15:0]   fired_ext;
    logic [CNT_W-1:0]         count;
    logic [CNT_W-1:0]         count_next;
    logic [1:0]               status;

    assign advance   = cmd_vld_reg && (!rsp_vld_reg || rsp_ready);
    assign cmd_ready = !cmd_vld_reg || advance;
    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

    assign prescale_inc = prescale_reg + 8'd1;

    always_comb
    begin
        slot_cmd.exec = advance;
        slot_cmd.op   = OP_NONE;
        prescale_next = prescale_reg;
        unique case (cmd_reg.func)
            FUNC_TICK:
            begin
                if (prescale_inc == tick_divide_reg)
                begin
                    slot_cmd.op   = OP_PASS;
                    prescale_next = 8'd0;
                end
                else
                begin
                    prescale_next = prescale_inc;
                end
            end
            FUNC_CREATE:  slot_cmd.op = OP_CREATE;
            FUNC_SUSPEND: slot_cmd.op = OP_SUSPEND;
            FUNC_RESUME:  slot_cmd.op = OP_RESUME;
            FUNC_DELETE:  slot_cmd.op = OP_DELETE;
            default:      slot_cmd.op = OP_NONE;
        endcase
    end

    ptrs_slot_table u_slot_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (slot_cmd),
        .period      (COUNT_WIDTH'(cmd_reg.period)),
        .first_delay (COUNT_WIDTH'(cmd_reg.first_delay)),
        .task_index  (cmd_reg.task_index),
        .fired       (fired),
        .count       (count),
        .count_next  (count_next),
        .status      (status)
    );

    assign fired_ext           = (TASK_SLOTS + 16)'(fired);
    assign rsp_next.fire_mask  = fired_ext[15:0];
    assign rsp_next.task_count = 5'(count_next);
    assign rsp_next.status     = status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_vld_reg     <= 1'b0;
            rsp_vld_reg     <= 1'b0;
            prescale_reg    <= 8'd0;
            tick_divide_reg <= TICK_DIVIDE_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                tick_divide_reg <= cfg_wdata;
            end
            if (cmd_ready)
            begin
                cmd_vld_reg <= cmd_valid;
            end
            if (advance)
            begin
                rsp_vld_reg  <= 1'b1;
                prescale_reg <= prescale_next;
            end
            else if (rsp_ready)
            begin
                rsp_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ready && cmd_valid)
        begin
            cmd_reg <= cmd;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count <= CNT_W'(TASK_SLOTS))
        else $error("Task count exceeds the slot table size.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && fired != '0) |-> (slot_cmd.op == OP_PASS))
        else $error("Fire bits raised by an item that is not a scheduler pass.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && status == STATUS_FULL) |-> (count == CNT_W'(TASK_SLOTS)))
        else $error("Table full reported while a slot is free.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && slot_cmd.op == OP_PASS) |=> (prescale_reg == 8'd0))
        else $error("Prescaler not cleared after a scheduler pass.");

endmodule
